// ===== rtl/core/chm_pkg.sv =====
// chm_pkg: shared constants, types and functions of the chained hash map engine
// prime table, key mixer, datapath command and status types
// no dependencies
package chm_pkg;

    localparam int BUCKET_SLOTS = 1024;
    localparam int NODE_SLOTS   = 1024;

    localparam int NADDR_W = $clog2(NODE_SLOTS);
    localparam int NODE_W  = NADDR_W + 1;
    localparam int BADDR_W = $clog2(BUCKET_SLOTS);
    localparam int COUNT_W = NODE_W;
    localparam int REQ_W   = 10;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int PRIME_W = BADDR_W + 1;
    localparam int THR_W   = ((NODE_W + 2) > (BADDR_W + 3)) ? (NODE_W + 2) : (BADDR_W + 3);
    localparam int PADDR_W = 3;

    localparam int IN_W  = 8 * ((MODE_W + KEY_W + VAL_W + 7) / 8);
    localparam int OUT_W = 8 * ((1 + VAL_W + STAT_W + COUNT_W + 7) / 8);

    localparam logic [NODE_W-1:0] NIL = NODE_W'(NODE_SLOTS);

    localparam int PRIME_COUNT = 16;
    localparam int IDX_W       = $clog2(PRIME_COUNT);
    localparam int unsigned PRIME_TAB [PRIME_COUNT] = '{
        3, 7, 13, 29, 53, 97, 193, 389, 769, 1543, 3079, 6151,
        12289, 24593, 49157, 98317
    };

    function automatic int top_index();
        int t;
        t = 0;
        for (int i = 0; i < PRIME_COUNT; i++)
        begin
            if (PRIME_TAB[i] <= BUCKET_SLOTS)
                t = i;
        end
        return t;
    endfunction

    localparam int TOP_INDEX = top_index();

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    localparam logic [PADDR_W-1:0] REG_REQUESTED_BUCKETS = 3'd0;

    function automatic logic [PRIME_W-1:0] prime_of(input logic [IDX_W-1:0] idx);
        return PRIME_W'(PRIME_TAB[idx]);
    endfunction

    function automatic logic [THR_W-1:0] thr_of(input logic [IDX_W-1:0] idx);
        return THR_W'(3 * PRIME_TAB[idx]);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [REQ_W-1:0] req);
        logic [IDX_W-1:0] r;
        r = IDX_W'(TOP_INDEX);
        for (int i = TOP_INDEX; i >= 0; i--)
        begin
            if (PRIME_TAB[i] >= 32'(req))
                r = IDX_W'(i);
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] mix(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] i;
        i = k;
        i = i + ~(i << 9);
        i = i ^ ((i >> 14) | (i << 18));
        i = i + (i << 4);
        i = i ^ ((i >> 10) | (i << 22));
        return i;
    endfunction

    typedef enum logic [5:0] {
        OP_NOP, OP_ACCEPT, OP_CLR_START, OP_SWEEP, OP_HASH_KEY, OP_SET_BUCKET,
        OP_LOAD_HEAD, OP_READ_NODE, OP_CMP_NODE, OP_SET_DUP, OP_SET_FULL,
        OP_SET_NOTFOUND, OP_WR_VAL, OP_RD_VAL, OP_LOAD_VAL, OP_UNLINK,
        OP_FREE_NODE, OP_INS_RD, OP_INS_WR, OP_G_INIT, OP_G_RD_HEAD,
        OP_G_LOAD_HEAD, OP_G_PUSH, OP_G_NEXT_NODE, OP_G_NEXT_BUCKET, OP_G_GROW,
        OP_G_RD_GATHER, OP_G_RD_KEY, OP_G_HASH_NODE, OP_G_RD_TAIL, OP_G_PLACE,
        OP_G_LINK, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic              mod_done;
        logic              key_match;
        logic              cur_nil;
        logic              found;
        logic [MODE_W-1:0] mode;
        logic              need_grow;
        logic              at_top;
        logic              pool_empty;
        logic              swp_last;
        logic              swp_len_last;
        logic              gb_last;
        logic              k_end;
        logic              cfg_wr;
        logic              out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/chm_ram.sv =====
// chm_ram: generic single write port, single read port ram with registered read
// no dependencies
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/chm_mod.sv =====
// chm_mod: bit-serial remainder of a 32-bit word by the bucket prime
// one dividend bit per cycle; depends on chm_pkg
module chm_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [chm_pkg::KEY_W-1:0]     dividend,
    input  logic [chm_pkg::PRIME_W-1:0]   divisor,
    output logic                          busy,
    output logic [chm_pkg::BADDR_W-1:0]   rem
);
    import chm_pkg::*;

    localparam int CNT_W = $clog2(KEY_W + 1);

    logic [KEY_W-1:0]   val_reg, val_next;
    logic [BADDR_W-1:0] rem_reg, rem_next;
    logic [PRIME_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [PRIME_W-1:0] trial;
    logic [PRIME_W-1:0] diff;

    always_comb
    begin
        trial     = {rem_reg, val_reg[KEY_W-1]};
        diff      = (trial >= div_reg) ? (trial - div_reg) : trial;
        val_next  = val_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            val_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(KEY_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the prime, so it fits the bucket index
            val_next  = val_reg << 1;
            rem_next  = diff[BADDR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            val_reg  <= val_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/core/chm_datapath.sv =====
// chm_datapath: table memories, pointers, counters, config register and result register
// executes one command per cycle; depends on chm_pkg, chm_ram, chm_mod
module chm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chm_pkg::dp_cmd_t              cmd,
    output chm_pkg::dp_stat_t             stat,
    input  logic [chm_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [chm_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [chm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata
);
    import chm_pkg::*;

    // registers
    logic [IDX_W-1:0]   prime_idx_reg, prime_idx_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [NODE_W-1:0]  free_head_reg, free_head_next;
    logic [NODE_W-1:0]  bump_reg, bump_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic [BADDR_W-1:0] bucket_reg, bucket_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [NODE_W-1:0]  prev_reg, prev_next;
    logic [NODE_W-1:0]  nxt_reg, nxt_next;
    logic [NODE_W-1:0]  tail_reg, tail_next;
    logic               found_reg, found_next;
    logic [VAL_W-1:0]   rd_reg, rd_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [BADDR_W-1:0] swp_reg, swp_next;
    logic [BADDR_W-1:0] gb_reg, gb_next;
    logic [NODE_W-1:0]  m_reg, m_next;
    logic [NODE_W-1:0]  k_reg, k_next;
    logic               virt_reg;
    logic [NODE_W-1:0]  laddr_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [VAL_W-1:0]   out_rd_reg, out_rd_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    // memory ports
    logic               heads_we, tails_we, gather_we, keys_we, vals_we, links_we;
    logic [BADDR_W-1:0] heads_waddr, heads_raddr, tails_waddr, tails_raddr;
    logic [NODE_W-1:0]  heads_wdata, heads_q, tails_wdata, tails_q;
    logic [NADDR_W-1:0] gather_waddr, gather_raddr, gather_wdata, gather_q;
    logic [NADDR_W-1:0] keys_waddr, keys_raddr, vals_waddr, vals_raddr;
    logic [NADDR_W-1:0] links_waddr;
    logic [KEY_W-1:0]   keys_wdata, keys_q;
    logic [VAL_W-1:0]   vals_wdata, vals_q;
    logic [NODE_W-1:0]  links_wdata, links_q, links_rnode;
    logic [NODE_W-1:0]  link_out;

    logic               mod_start, mod_src, mod_busy;
    logic [BADDR_W-1:0] mod_rem;
    logic [PRIME_W-1:0] prime;
    logic               cfg_we;

    chm_ram #(.WIDTH(NODE_W), .DEPTH(BUCKET_SLOTS)) u_heads (
        .clk(clk), .we(heads_we), .waddr(heads_waddr), .wdata(heads_wdata),
        .raddr(heads_raddr), .rdata(heads_q));
    chm_ram #(.WIDTH(NODE_W), .DEPTH(BUCKET_SLOTS)) u_tails (
        .clk(clk), .we(tails_we), .waddr(tails_waddr), .wdata(tails_wdata),
        .raddr(tails_raddr), .rdata(tails_q));
    chm_ram #(.WIDTH(NADDR_W), .DEPTH(NODE_SLOTS)) u_gather (
        .clk(clk), .we(gather_we), .waddr(gather_waddr), .wdata(gather_wdata),
        .raddr(gather_raddr), .rdata(gather_q));
    chm_ram #(.WIDTH(KEY_W), .DEPTH(NODE_SLOTS)) u_keys (
        .clk(clk), .we(keys_we), .waddr(keys_waddr), .wdata(keys_wdata),
        .raddr(keys_raddr), .rdata(keys_q));
    chm_ram #(.WIDTH(VAL_W), .DEPTH(NODE_SLOTS)) u_vals (
        .clk(clk), .we(vals_we), .waddr(vals_waddr), .wdata(vals_wdata),
        .raddr(vals_raddr), .rdata(vals_q));
    chm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_links (
        .clk(clk), .we(links_we), .waddr(links_waddr), .wdata(links_wdata),
        .raddr(links_rnode[NADDR_W-1:0]), .rdata(links_q));

    assign prime = prime_of(prime_idx_reg);

    chm_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start),
        .dividend(mix(mod_src ? keys_q : key_reg)),
        .divisor(prime), .busy(mod_busy), .rem(mod_rem));

    // nodes at or above the fill mark were never written: their link is the next node
    assign link_out = virt_reg ? (laddr_reg + 1'b1) : links_q;

    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = (paddr[2] == REG_REQUESTED_BUCKETS[2]) ? {{(32-REQ_W){1'b0}}, req_reg} : '0;

    always_comb
    begin
        prime_idx_next  = prime_idx_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        free_head_next  = free_head_reg;
        bump_next       = bump_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        bucket_next     = bucket_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        tail_next       = tail_reg;
        found_next      = found_reg;
        rd_next         = rd_reg;
        status_next     = status_reg;
        swp_next        = swp_reg;
        gb_next         = gb_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        out_found_next  = out_found_reg;
        out_rd_next     = out_rd_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;

        heads_we     = 1'b0;
        heads_waddr  = bucket_reg;
        heads_wdata  = cur_reg;
        heads_raddr  = bucket_reg;
        tails_we     = 1'b0;
        tails_waddr  = bucket_reg;
        tails_wdata  = cur_reg;
        tails_raddr  = bucket_reg;
        gather_we    = 1'b0;
        gather_waddr = m_reg[NADDR_W-1:0];
        gather_wdata = cur_reg[NADDR_W-1:0];
        gather_raddr = k_reg[NADDR_W-1:0];
        keys_we      = 1'b0;
        keys_waddr   = cur_reg[NADDR_W-1:0];
        keys_wdata   = key_reg;
        keys_raddr   = cur_reg[NADDR_W-1:0];
        vals_we      = 1'b0;
        vals_waddr   = cur_reg[NADDR_W-1:0];
        vals_wdata   = value_reg;
        vals_raddr   = cur_reg[NADDR_W-1:0];
        links_we     = 1'b0;
        links_waddr  = cur_reg[NADDR_W-1:0];
        links_wdata  = NIL;
        links_rnode  = cur_reg;
        mod_start    = 1'b0;
        mod_src      = 1'b0;

        unique case (cmd.op)
            OP_NOP:
            begin
            end
            OP_ACCEPT:
            begin
                mode_next   = s_tdata[MODE_W-1:0];
                key_next    = s_tdata[MODE_W +: KEY_W];
                value_next  = s_tdata[MODE_W+KEY_W +: VAL_W];
                found_next  = 1'b0;
                rd_next     = '0;
                status_next = ST_OK;
            end
            OP_CLR_START:
            begin
                count_next     = '0;
                free_head_next = '0;
                bump_next      = '0;
                swp_next       = '0;
            end
            OP_SWEEP:
            begin
                heads_we    = 1'b1;
                heads_waddr = swp_reg;
                heads_wdata = NIL;
                tails_we    = 1'b1;
                tails_waddr = swp_reg;
                tails_wdata = NIL;
                swp_next    = swp_reg + 1'b1;
            end
            OP_HASH_KEY:
                mod_start = 1'b1;
            OP_SET_BUCKET:
            begin
                bucket_next = mod_rem;
                heads_raddr = mod_rem;
            end
            OP_LOAD_HEAD:
            begin
                cur_next  = heads_q;
                prev_next = NIL;
            end
            OP_READ_NODE:
            begin
            end
            OP_CMP_NODE:
            begin
                nxt_next = link_out;
                if (keys_q == key_reg)
                    found_next = 1'b1;
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_out;
                end
            end
            OP_SET_DUP:
                status_next = ST_DUPLICATE;
            OP_SET_FULL:
                status_next = ST_FULL;
            OP_SET_NOTFOUND:
                status_next = ST_NOT_FOUND;
            OP_WR_VAL:
                vals_we = 1'b1;
            OP_RD_VAL:
            begin
            end
            OP_LOAD_VAL:
                rd_next = vals_q;
            OP_UNLINK:
            begin
                if (prev_reg == NIL)
                begin
                    heads_we    = 1'b1;
                    heads_wdata = nxt_reg;
                end
                else
                begin
                    links_we    = 1'b1;
                    links_waddr = prev_reg[NADDR_W-1:0];
                    links_wdata = nxt_reg;
                end
            end
            OP_FREE_NODE:
            begin
                links_we       = 1'b1;
                links_wdata    = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
            end
            OP_INS_RD:
                links_rnode = free_head_reg;
            OP_INS_WR:
            begin
                free_head_next = link_out;
                keys_we        = 1'b1;
                keys_waddr     = free_head_reg[NADDR_W-1:0];
                vals_we        = 1'b1;
                vals_waddr     = free_head_reg[NADDR_W-1:0];
                links_we       = 1'b1;
                links_waddr    = free_head_reg[NADDR_W-1:0];
                links_wdata    = heads_q;
                heads_we       = 1'b1;
                heads_wdata    = free_head_reg;
                count_next     = count_reg + 1'b1;
                if (free_head_reg == bump_reg)
                    bump_next = bump_reg + 1'b1;
            end
            OP_G_INIT:
            begin
                gb_next = '0;
                m_next  = '0;
            end
            OP_G_RD_HEAD:
                heads_raddr = gb_reg;
            OP_G_LOAD_HEAD:
                cur_next = heads_q;
            OP_G_PUSH:
            begin
                gather_we = 1'b1;
                m_next    = m_reg + 1'b1;
            end
            OP_G_NEXT_NODE:
                cur_next = link_out;
            OP_G_NEXT_BUCKET:
                gb_next = gb_reg + 1'b1;
            OP_G_GROW:
            begin
                prime_idx_next = prime_idx_reg + 1'b1;
                swp_next       = '0;
                k_next         = '0;
            end
            OP_G_RD_GATHER:
            begin
            end
            OP_G_RD_KEY:
            begin
                cur_next   = {1'b0, gather_q};
                keys_raddr = gather_q;
            end
            OP_G_HASH_NODE:
            begin
                mod_start = 1'b1;
                mod_src   = 1'b1;
            end
            OP_G_RD_TAIL:
            begin
                bucket_next = mod_rem;
                tails_raddr = mod_rem;
            end
            OP_G_PLACE:
            begin
                links_we  = 1'b1;
                tails_we  = 1'b1;
                tail_next = tails_q;
                if (tails_q == NIL)
                    heads_we = 1'b1;
            end
            OP_G_LINK:
            begin
                if (tail_reg != NIL)
                begin
                    links_we    = 1'b1;
                    links_waddr = tail_reg[NADDR_W-1:0];
                    links_wdata = cur_reg;
                end
                k_next = k_reg + 1'b1;
            end
            OP_OUT:
            begin
                out_valid_next  = 1'b1;
                out_found_next  = found_reg;
                out_rd_next     = rd_reg;
                out_status_next = status_reg;
                out_count_next  = count_reg;
            end
            default:
            begin
            end
        endcase

        // a register write re-sizes and empties the table
        if (cfg_we)
        begin
            req_next       = pwdata[REQ_W-1:0];
            prime_idx_next = pick_index(pwdata[REQ_W-1:0]);
            count_next     = '0;
            free_head_next = '0;
            bump_next      = '0;
            swp_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_idx_reg <= '0;
            req_reg       <= '0;
            count_reg     <= '0;
            free_head_reg <= '0;
            bump_reg      <= '0;
            swp_reg       <= '0;
            gb_reg        <= '0;
            m_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prime_idx_reg <= prime_idx_next;
            req_reg       <= req_next;
            count_reg     <= count_next;
            free_head_reg <= free_head_next;
            bump_reg      <= bump_next;
            swp_reg       <= swp_next;
            gb_reg        <= gb_next;
            m_reg         <= m_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        bucket_reg     <= bucket_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        tail_reg       <= tail_next;
        found_reg      <= found_next;
        rd_reg         <= rd_next;
        status_reg     <= status_next;
        virt_reg       <= (links_rnode >= bump_reg);
        laddr_reg      <= links_rnode;
        out_found_reg  <= out_found_next;
        out_rd_reg     <= out_rd_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        stat.mod_done     = !mod_busy;
        stat.key_match    = (keys_q == key_reg);
        stat.cur_nil      = (cur_reg == NIL);
        stat.found        = found_reg;
        stat.mode         = mode_reg;
        stat.need_grow    = ({count_reg, 2'b00} >= thr_of(prime_idx_reg));
        stat.at_top       = (prime_idx_reg >= IDX_W'(TOP_INDEX));
        stat.pool_empty   = (free_head_reg == NIL);
        stat.swp_last     = (swp_reg == BADDR_W'(BUCKET_SLOTS - 1));
        stat.swp_len_last = ({1'b0, swp_reg} == (prime - 1'b1));
        stat.gb_last      = ({1'b0, gb_reg} == (prime - 1'b1));
        stat.k_end        = (k_reg == m_reg);
        stat.cfg_wr       = cfg_we;
        stat.out_free     = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - 1 - VAL_W - STAT_W - COUNT_W){1'b0}},
                       out_count_reg, out_status_reg, out_rd_reg, out_found_reg};

endmodule

// ===== rtl/core/chm_ctrl.sv =====
// chm_ctrl: sequencer of the hash map engine, one command to the datapath per cycle
// depends on chm_pkg
module chm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  chm_pkg::dp_stat_t stat,
    output chm_pkg::dp_cmd_t  cmd
);
    import chm_pkg::*;

    typedef enum logic [24:0] {
        S_CLR     = 25'h0000001,
        S_IDLE    = 25'h0000002,
        S_DISP    = 25'h0000004,
        S_HASH    = 25'h0000008,
        S_HEAD    = 25'h0000010,
        S_WALK    = 25'h0000020,
        S_CMP     = 25'h0000040,
        S_RESOLVE = 25'h0000080,
        S_LLOAD   = 25'h0000100,
        S_REM2    = 25'h0000200,
        S_INS_RD  = 25'h0000400,
        S_INS_WR  = 25'h0000800,
        S_G_HEAD  = 25'h0001000,
        S_G_HWAIT = 25'h0002000,
        S_G_WALK  = 25'h0004000,
        S_G_LWAIT = 25'h0008000,
        S_G_SWEEP = 25'h0010000,
        S_G_RD    = 25'h0020000,
        S_G_GW    = 25'h0040000,
        S_G_KW    = 25'h0080000,
        S_G_MOD   = 25'h0100000,
        S_G_TW    = 25'h0200000,
        S_G_LK    = 25'h0400000,
        S_I_HASH  = 25'h0800000,
        S_DONE    = 25'h1000000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_item_reg, clr_item_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        clr_item_next = clr_item_reg;
        cmd.op        = OP_NOP;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_SWEEP;
                if (stat.swp_last)
                    state_next = clr_item_reg ? S_DONE : S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.mode <= MODE_REMOVE)
                begin
                    cmd.op     = OP_HASH_KEY;
                    state_next = S_HASH;
                end
                else if (stat.mode == MODE_CLEAR)
                begin
                    cmd.op        = OP_CLR_START;
                    clr_item_next = 1'b1;
                    state_next    = S_CLR;
                end
                else
                    state_next = S_DONE;
            end
            S_HASH:
            begin
                if (stat.mod_done)
                begin
                    cmd.op     = OP_SET_BUCKET;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.op     = OP_LOAD_HEAD;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.cur_nil)
                    state_next = S_RESOLVE;
                else
                begin
                    cmd.op     = OP_READ_NODE;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.op     = OP_CMP_NODE;
                state_next = stat.key_match ? S_RESOLVE : S_WALK;
            end
            S_RESOLVE:
            begin
                state_next = S_DONE;
                if (stat.mode == MODE_INSERT)
                begin
                    priority if (stat.found)
                        cmd.op = OP_SET_DUP;
                    else if (stat.pool_empty || (stat.need_grow && stat.at_top))
                        cmd.op = OP_SET_FULL;
                    else if (stat.need_grow)
                    begin
                        cmd.op     = OP_G_INIT;
                        state_next = S_G_HEAD;
                    end
                    else
                    begin
                        cmd.op     = OP_INS_RD;
                        state_next = S_INS_WR;
                    end
                end
                else if (!stat.found)
                    cmd.op = OP_SET_NOTFOUND;
                else if (stat.mode == MODE_REPLACE)
                    cmd.op = OP_WR_VAL;
                else if (stat.mode == MODE_LOOKUP)
                begin
                    cmd.op     = OP_RD_VAL;
                    state_next = S_LLOAD;
                end
                else
                begin
                    cmd.op     = OP_UNLINK;
                    state_next = S_REM2;
                end
            end
            S_LLOAD:
            begin
                cmd.op     = OP_LOAD_VAL;
                state_next = S_DONE;
            end
            S_REM2:
            begin
                cmd.op     = OP_FREE_NODE;
                state_next = S_DONE;
            end
            S_INS_RD:
            begin
                cmd.op     = OP_INS_RD;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.op     = OP_INS_WR;
                state_next = S_DONE;
            end
            // gather every chain in bucket order
            S_G_HEAD:
            begin
                cmd.op     = OP_G_RD_HEAD;
                state_next = S_G_HWAIT;
            end
            S_G_HWAIT:
            begin
                cmd.op     = OP_G_LOAD_HEAD;
                state_next = S_G_WALK;
            end
            S_G_WALK:
            begin
                priority if (!stat.cur_nil)
                begin
                    cmd.op     = OP_G_PUSH;
                    state_next = S_G_LWAIT;
                end
                else if (stat.gb_last)
                begin
                    cmd.op     = OP_G_GROW;
                    state_next = S_G_SWEEP;
                end
                else
                begin
                    cmd.op     = OP_G_NEXT_BUCKET;
                    state_next = S_G_HEAD;
                end
            end
            S_G_LWAIT:
            begin
                cmd.op     = OP_G_NEXT_NODE;
                state_next = S_G_WALK;
            end
            S_G_SWEEP:
            begin
                cmd.op = OP_SWEEP;
                if (stat.swp_len_last)
                    state_next = S_G_RD;
            end
            // re-append gathered nodes at the tails of the new buckets
            S_G_RD:
            begin
                if (stat.k_end)
                begin
                    cmd.op     = OP_HASH_KEY;
                    state_next = S_I_HASH;
                end
                else
                begin
                    cmd.op     = OP_G_RD_GATHER;
                    state_next = S_G_GW;
                end
            end
            S_G_GW:
            begin
                cmd.op     = OP_G_RD_KEY;
                state_next = S_G_KW;
            end
            S_G_KW:
            begin
                cmd.op     = OP_G_HASH_NODE;
                state_next = S_G_MOD;
            end
            S_G_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.op     = OP_G_RD_TAIL;
                    state_next = S_G_TW;
                end
            end
            S_G_TW:
            begin
                cmd.op     = OP_G_PLACE;
                state_next = S_G_LK;
            end
            S_G_LK:
            begin
                cmd.op     = OP_G_LINK;
                state_next = S_G_RD;
            end
            S_I_HASH:
            begin
                if (stat.mod_done)
                begin
                    cmd.op     = OP_SET_BUCKET;
                    state_next = S_INS_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_CLR;
        endcase

        // a register write restarts the clearing pass
        if (stat.cfg_wr)
        begin
            state_next    = S_CLR;
            clr_item_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_item_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_item_reg <= clr_item_next;
        end
    end

endmodule

// ===== rtl/core/chained_hash_map_engine.sv =====
// chained_hash_map_engine: top level of the chained hash map engine
// joins chm_ctrl and chm_datapath; depends on chm_pkg
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       mode, key, value
// m_*       out  m_tvalid / m_tready       found, read_value, status, entry_count
// apb       in   psel, penable, pwrite     requested_buckets at byte address 0
//
// one item at a time: an item takes longer for every chain node walked, and its time is
// set by the bit-serial remainder unit and the registered ram reads of the chain walk.
// an insert that grows the table also walks every old bucket and node, sweeps the new
// buckets and rehashes every stored entry and then its own key; a clear sweeps every
// bucket slot.
// after reset and each register write a sweep of every bucket slot empties the heads.
// a finished result waits in the output register while the next item is taken.
module chained_hash_map_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[2:0], key[34:3], value[66:35]
    input  logic [chm_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found[0], read_value[32:1], status[34:33], entry_count[45:35]
    output logic [chm_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [chm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import chm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign pready = 1'b1;

    chm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .stat(stat), .cmd(cmd));

    chm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata));

endmodule

// ===== dv/chained_hash_map_engine_tb.sv =====
// chained_hash_map_engine_tb: self-checking bench for the chained hash map engine
// drives the stream and apb ports, predicts results from a key-value shadow map or takes them from typed rows
// depends on chm_pkg and the rtl of chained_hash_map_engine
module chained_hash_map_engine_tb;
    import chm_pkg::*;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_t;

    typedef struct {
        logic               found;
        logic [VAL_W-1:0]   read_value;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] entry_count;
    } map_result_t;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        bit                 typed;
        map_result_t        res;
    } dir_row_t;

    localparam int unsigned BUCKET_PRIMES [9] = '{3, 7, 13, 29, 53, 97, 193, 389, 769};
    localparam int LAST_PRIME = 8;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // shadow of the map: chain order never shows in a result, so a keyed array suffices
    logic [VAL_W-1:0]  shadow_map [logic [KEY_W-1:0]];
    int                shadow_prime;
    int                shadow_count;
    map_result_t       pending_results [$];
    logic [KEY_W-1:0]  key_pool [$];
    idle_t             idle_mode;
    int                mismatches;
    int                items_sent;
    int                results_seen;
    int                full_refusals;
    int                grows_seen;

    chained_hash_map_engine dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // idle share in percent for the current phase
    function automatic int idle_pct();
        if (idle_mode == IDLE_BOTH)
            return 26;
        else if (idle_mode == IDLE_SEND || idle_mode == IDLE_RECV)
            return 53;
        return 0;
    endfunction

    function automatic map_result_t apply_map_op(input logic [MODE_W-1:0] mode,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [VAL_W-1:0] value);
        map_result_t r;
        bit hit;
        r = '{1'b0, '0, ST_OK, '0};
        hit = shadow_map.exists(key);
        if (mode <= MODE_REMOVE)
            r.found = hit;
        if (mode == MODE_INSERT)
        begin
            if (hit)
                r.status = ST_DUPLICATE;
            else if (4 * shadow_count >= 3 * BUCKET_PRIMES[shadow_prime]
                     && shadow_prime >= LAST_PRIME)
                r.status = ST_FULL;
            else
            begin
                if (4 * shadow_count >= 3 * BUCKET_PRIMES[shadow_prime])
                begin
                    shadow_prime++;
                    grows_seen++;
                end
                shadow_map[key] = value;
                shadow_count++;
            end
        end
        else if (mode <= MODE_REMOVE && !hit)
            r.status = ST_NOT_FOUND;
        else if (mode == MODE_REPLACE)
            shadow_map[key] = value;
        else if (mode == MODE_LOOKUP)
            r.read_value = shadow_map[key];
        else if (mode == MODE_REMOVE)
        begin
            shadow_map.delete(key);
            shadow_count--;
        end
        else if (mode == MODE_CLEAR)
        begin
            shadow_map.delete();
            shadow_count = 0;
        end
        if (r.status == ST_FULL)
            full_refusals++;
        r.entry_count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // result side: ready pattern and checking, both on pre-edge values
    always @(negedge clk)
        if (!rst_n)
            m_tready <= 1'b1;
        else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(99) >= idle_pct());
        else
            m_tready <= 1'b1;

    always @(posedge clk)
    begin
        map_result_t want;
        map_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found       = m_tdata[0];
            got.read_value  = m_tdata[32:1];
            got.status      = m_tdata[34:33];
            got.entry_count = m_tdata[45:35];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: found %0d value %h status %0d count %0d",
                             got.found, got.read_value, got.status, got.entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.read_value !== want.read_value
                    || got.status !== want.status || got.entry_count !== want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected found %0d value %h status %0d count %0d,",
                                  " got found %0d value %h status %0d count %0d"},
                                 want.found, want.read_value, want.status, want.entry_count,
                                 got.found, got.read_value, got.status, got.entry_count);
                end
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value, input bit typed,
                             input map_result_t typed_res);
        map_result_t predicted;
        int gap;
        gap = 0;
        if ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
            && $urandom_range(99) < idle_pct())
            gap = $urandom_range(4, 1);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({value, key, mode});
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_map_op(mode, key, value);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (64) @(negedge clk);
    endtask

    task automatic write_requested(input logic [REQ_W-1:0] req);
        int pick;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_REQUESTED_BUCKETS;
        pwdata  <= 32'(req);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pick = LAST_PRIME;
        for (int i = LAST_PRIME; i >= 0; i--)
            if (BUCKET_PRIMES[i] >= req)
                pick = i;
        shadow_prime = pick;
        shadow_map.delete();
        shadow_count = 0;
    endtask

    task automatic random_items(input int n, input bit filling);
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            // filling runs past the load limit so that refusals show up
            if (filling)
                mode = (pick < 95) ? MODE_INSERT : MODE_LOOKUP;
            else
                mode = (pick < 35) ? MODE_INSERT : (pick < 50) ? MODE_REPLACE :
                       (pick < 75) ? MODE_LOOKUP : (pick < 95) ? MODE_REMOVE :
                       (pick < 96) ? MODE_CLEAR : MODE_W'($urandom_range(7, 5));
            if (mode == MODE_INSERT && (filling || $urandom_range(99) < 30))
            begin
                key = $urandom;
                if (key_pool.size() < 32)
                    key_pool.push_back(key);
            end
            else if (key_pool.size() != 0 && $urandom_range(99) < 75)
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                key = $urandom;
            send_item(mode, key, $urandom, 1'b0, '{1'b0, '0, ST_OK, '0});
            // one hold-off until the engine has answered everything
            if (!filling && i == n / 2)
                drain_results();
        end
    endtask

    initial
    begin
        dir_row_t rows [$];
        idle_t    phase_idle [6];
        int       phase_req  [6];
        int       phase_len  [6];
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b1;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_mode    = IDLE_NONE;
        shadow_prime = 0;
        shadow_count = 0;
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        full_refusals = 0;
        grows_seen   = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // empty table of three buckets after reset, then edge keys, grow and clear
        rows = '{
            '{MODE_LOOKUP,  32'h0,        32'h0,        1, '{0, 32'h0, ST_NOT_FOUND, 0}},
            '{MODE_INSERT,  32'h0,        32'h0,        1, '{0, 32'h0, ST_OK, 1}},
            '{MODE_INSERT,  32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{0, 32'h0, ST_OK, 2}},
            '{MODE_INSERT,  32'h0,        32'h5A5A5A5A, 1, '{1, 32'h0, ST_DUPLICATE, 2}},
            '{MODE_LOOKUP,  32'hFFFFFFFF, 32'h0,        1, '{1, 32'hFFFFFFFF, ST_OK, 2}},
            '{MODE_REPLACE, 32'h0,        32'hFFFFFFFF, 1, '{1, 32'h0, ST_OK, 2}},
            '{MODE_LOOKUP,  32'h0,        32'h0,        0, '{0, 0, ST_OK, 0}},
            '{MODE_REPLACE, 32'h12345678, 32'h1,        1, '{0, 32'h0, ST_NOT_FOUND, 2}},
            '{MODE_REMOVE,  32'hFFFFFFFF, 32'h0,        1, '{1, 32'h0, ST_OK, 1}},
            '{MODE_REMOVE,  32'hFFFFFFFF, 32'h0,        1, '{0, 32'h0, ST_NOT_FOUND, 1}},
            '{MODE_INSERT,  32'h80000000, 32'h00000001, 0, '{0, 0, ST_OK, 0}},
            '{MODE_INSERT,  32'h7FFFFFFF, 32'hFFFFFFFE, 0, '{0, 0, ST_OK, 0}},
            '{MODE_INSERT,  32'h00000001, 32'h80000000, 0, '{0, 0, ST_OK, 0}},
            '{MODE_INSERT,  32'h00000002, 32'h7FFFFFFF, 0, '{0, 0, ST_OK, 0}},
            '{MODE_LOOKUP,  32'h80000000, 32'h0,        0, '{0, 0, ST_OK, 0}},
            '{MODE_LOOKUP,  32'h7FFFFFFF, 32'h0,        0, '{0, 0, ST_OK, 0}},
            '{3'd5,         32'h0,        32'h0,        0, '{0, 0, ST_OK, 0}},
            '{3'd6,         32'hFFFFFFFF, 32'hFFFFFFFF, 0, '{0, 0, ST_OK, 0}},
            '{3'd7,         32'h0,        32'h0,        0, '{0, 0, ST_OK, 0}},
            '{MODE_CLEAR,   32'h0,        32'h0,        1, '{0, 32'h0, ST_OK, 0}},
            '{MODE_LOOKUP,  32'h0,        32'h0,        1, '{0, 32'h0, ST_NOT_FOUND, 0}},
            '{MODE_INSERT,  32'hDEADBEEF, 32'hCAFEF00D, 1, '{0, 32'h0, ST_OK, 1}}
        };
        @(negedge clk);
        foreach (rows[i])
            send_item(rows[i].mode, rows[i].key, rows[i].value, rows[i].typed, rows[i].res);
        drain_results();

        // largest table filled to its load limit first, then other settings
        phase_req  = '{769, 0, 1023, 4, 100, 30};
        phase_idle = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
        phase_len  = '{640, 120, 120, 120, 110, 110};
        for (int p = 0; p < 6; p++)
        begin
            write_requested(REQ_W'(phase_req[p]));
            key_pool.delete();
            idle_mode = phase_idle[p];
            random_items(phase_len[p], p == 0);
            drain_results();
        end

        $display("%0d items sent, %0d results checked, %0d table grows, %0d full refusals",
                 items_sent, results_seen, grows_seen, full_refusals);
        $display("register settings 0 to 1023 under four idling patterns");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("chained_hash_map_engine_tb: PASS");
        else
            $display("chained_hash_map_engine_tb: FAIL");
        $finish;
    end

    initial
    begin
        #(8 * 3000000);
        $display("chained_hash_map_engine_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/chm_pkg.sv
rtl/core/chm_ram.sv
rtl/core/chm_mod.sv
rtl/core/chm_datapath.sv
rtl/core/chm_ctrl.sv
rtl/core/chained_hash_map_engine.sv
dv/chained_hash_map_engine_tb.sv
